// File: hw/rtl/fcp_pkg.sv
// Shared types, constants and lookup functions for the form credential parser.
// Used by the parser, the result queue and the top level; no dependencies.
`timescale 1ns / 1ps

package fcp_pkg;

  // Largest body, in bytes, that is parsed before it counts as oversize.
  localparam int MAX_BODY   = 512;
  localparam int BODY_CNT_W = $clog2(MAX_BODY + 2);

  localparam int LEN_W        = 7;
  localparam int POS_W        = 6;
  localparam int NAME_IDX_W   = 4;

  localparam logic [NAME_IDX_W-1:0] NAME_IDX_SAT  = 4'd15;
  localparam logic [NAME_IDX_W-1:0] SSID_NAME_LEN = 4'd4;
  localparam logic [NAME_IDX_W-1:0] PW_NAME_LEN   = 4'd8;

  localparam logic [LEN_W-1:0] LEN_SAT      = 7'd127;
  localparam logic [LEN_W-1:0] SSID_MAX_LEN = 7'd32;
  localparam logic [LEN_W-1:0] PW_MIN_LEN   = 7'd8;
  localparam logic [LEN_W-1:0] PW_MAX_LEN   = 7'd63;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7f;
  localparam logic [7:0] CHAR_TILDE = 8'h7e;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_EQ    = 8'h3d;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [2:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_BAD_FORM     = 3'd1,
    VERDICT_BAD_SSID     = 3'd2,
    VERDICT_BAD_PASSWORD = 3'd3,
    VERDICT_OVERSIZE     = 3'd4
  } verdict_e;

  typedef struct packed {
    logic             is_verdict;
    logic             field_tag;
    logic [POS_W-1:0] byte_position;
    logic [7:0]       value_byte;
    verdict_e         verdict;
    logic             end_of_run;
  } result_t;

  // Results of one parsed byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Expected name text: "ssid" padded with zero bytes, and "password".
  function automatic logic [7:0] ssid_name_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h73;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pw_name_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h70;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h73;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h77;
      3'd5:    c = 8'h6f;
      3'd6:    c = 8'h72;
      default: c = 8'h64;
    endcase
    return c;
  endfunction

  // Returns {valid, nibble} for a hex digit in either case.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/fcp_parse.sv
// Parser state and the per-byte update: percent decoding, name matching,
// value length and character checks, and the verdict. Depends on fcp_pkg.
`timescale 1ns / 1ps

module fcp_parse import fcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output push_t      push_o
);

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_e;

  esc_e                  esc_q, esc_d;
  logic [3:0]            upper_q, upper_d;
  logic                  in_value_q, in_value_d;
  logic [NAME_IDX_W-1:0] name_idx_q, name_idx_d;
  logic                  could_ssid_q, could_ssid_d;
  logic                  could_pw_q, could_pw_d;
  logic                  target_q, target_d;
  logic [1:0]            seen_q, seen_d;
  logic                  failed_q, failed_d;
  logic [LEN_W-1:0]      ssid_len_q, ssid_len_d;
  logic [LEN_W-1:0]      pw_len_q, pw_len_d;
  logic [1:0]            char_flags_q, char_flags_d;
  logic [BODY_CNT_W-1:0] body_cnt_q, body_cnt_d;

  logic             oversize;
  logic             dec_en;
  logic [7:0]       dec_byte;
  logic [4:0]       hex;
  logic [LEN_W-1:0] len_sel;
  logic             val_emit;
  logic             fail_final;
  result_t          val_res;
  result_t          ver_res;
  verdict_e         verdict;

  always_comb begin
    esc_d        = esc_q;
    upper_d      = upper_q;
    in_value_d   = in_value_q;
    name_idx_d   = name_idx_q;
    could_ssid_d = could_ssid_q;
    could_pw_d   = could_pw_q;
    target_d     = target_q;
    seen_d       = seen_q;
    failed_d     = failed_q;
    ssid_len_d   = ssid_len_q;
    pw_len_d     = pw_len_q;
    char_flags_d = char_flags_q;
    body_cnt_d   = body_cnt_q;

    oversize   = 1'b0;
    dec_en     = 1'b0;
    dec_byte   = '0;
    hex        = hex_decode(byte_i);
    len_sel    = target_q ? pw_len_q : ssid_len_q;
    val_emit   = 1'b0;
    fail_final = 1'b0;
    verdict    = VERDICT_OK;
    val_res    = '0;
    ver_res    = '0;
    push_o     = '0;

    if (fire_i) begin
      if (body_cnt_q <= BODY_CNT_W'(MAX_BODY)) begin
        body_cnt_d = body_cnt_q + 1'b1;
      end
      oversize = body_cnt_d > BODY_CNT_W'(MAX_BODY);

      if (!oversize && !failed_q) begin
        if (esc_q != ESC_NONE) begin
          if (!hex[4]) begin
            failed_d = 1'b1;
          end else if (esc_q == ESC_HIGH) begin
            upper_d = hex[3:0];
            esc_d   = ESC_LOW;
          end else begin
            esc_d    = ESC_NONE;
            dec_byte = {upper_q, hex[3:0]};
            if (dec_byte == 8'h00) begin
              failed_d = 1'b1;
            end else begin
              dec_en = 1'b1;
            end
          end
        end else if (byte_i == CHAR_AMP) begin
          if (!in_value_q) begin
            failed_d = 1'b1;
          end else begin
            upper_d      = '0;
            in_value_d   = 1'b0;
            name_idx_d   = '0;
            could_ssid_d = 1'b1;
            could_pw_d   = 1'b1;
          end
        end else if (byte_i == CHAR_EQ && !in_value_q) begin
          // The name ends here and must select a field that is not yet taken.
          if (could_ssid_q && name_idx_q == SSID_NAME_LEN && !seen_q[0]) begin
            target_d   = 1'b0;
            seen_d[0]  = 1'b1;
            in_value_d = 1'b1;
          end else if (could_pw_q && name_idx_q == PW_NAME_LEN && !seen_q[1]) begin
            target_d   = 1'b1;
            seen_d[1]  = 1'b1;
            in_value_d = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end else if (byte_i == CHAR_PLUS) begin
          dec_en   = 1'b1;
          dec_byte = CHAR_SPACE;
        end else if (byte_i == CHAR_PCT) begin
          esc_d = ESC_HIGH;
        end else begin
          dec_en   = 1'b1;
          dec_byte = byte_i;
        end
      end

      if (dec_en && !in_value_q) begin
        if (!name_idx_q[3]) begin
          if (ssid_name_char(name_idx_q[2:0]) != dec_byte) could_ssid_d = 1'b0;
          if (pw_name_char(name_idx_q[2:0]) != dec_byte) could_pw_d = 1'b0;
        end else begin
          could_ssid_d = 1'b0;
          could_pw_d   = 1'b0;
        end
        if (name_idx_q != NAME_IDX_SAT) begin
          name_idx_d = name_idx_q + 1'b1;
        end
      end else if (dec_en) begin
        if (!target_q) begin
          if (dec_byte < CHAR_SPACE || dec_byte == CHAR_DEL) char_flags_d[0] = 1'b1;
        end else begin
          if (dec_byte < CHAR_SPACE || dec_byte > CHAR_TILDE) char_flags_d[1] = 1'b1;
        end
        // Positions past the 6-bit range are not delivered.
        val_emit              = !len_sel[LEN_W-1];
        val_res.field_tag     = target_q;
        val_res.byte_position = len_sel[POS_W-1:0];
        val_res.value_byte    = dec_byte;
        if (len_sel != LEN_SAT) begin
          if (target_q) begin
            pw_len_d = len_sel + 1'b1;
          end else begin
            ssid_len_d = len_sel + 1'b1;
          end
        end
      end

      if (final_i) begin
        fail_final = failed_d || (esc_d != ESC_NONE) || !in_value_d || (seen_d != 2'b11);
        if (oversize) begin
          verdict = VERDICT_OVERSIZE;
        end else if (fail_final) begin
          verdict = VERDICT_BAD_FORM;
        end else if (ssid_len_d == '0 || ssid_len_d > SSID_MAX_LEN || char_flags_d[0]) begin
          verdict = VERDICT_BAD_SSID;
        end else if (pw_len_d != '0 && (pw_len_d < PW_MIN_LEN || pw_len_d > PW_MAX_LEN ||
                                        char_flags_d[1])) begin
          verdict = VERDICT_BAD_PASSWORD;
        end
        ver_res.is_verdict = 1'b1;
        ver_res.verdict    = verdict;
        ver_res.end_of_run = 1'b1;

        esc_d        = ESC_NONE;
        upper_d      = '0;
        in_value_d   = 1'b0;
        name_idx_d   = '0;
        could_ssid_d = 1'b1;
        could_pw_d   = 1'b1;
        target_d     = 1'b0;
        seen_d       = '0;
        failed_d     = 1'b0;
        ssid_len_d   = '0;
        pw_len_d     = '0;
        char_flags_d = '0;
        body_cnt_d   = '0;
      end

      if (val_emit && final_i) begin
        push_o.count  = 2'd2;
        push_o.first  = val_res;
        push_o.second = ver_res;
      end else if (val_emit) begin
        val_res.end_of_run = 1'b1;
        push_o.count       = 2'd1;
        push_o.first       = val_res;
      end else if (final_i) begin
        push_o.count = 2'd1;
        push_o.first = ver_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q        <= ESC_NONE;
      upper_q      <= '0;
      in_value_q   <= 1'b0;
      name_idx_q   <= '0;
      could_ssid_q <= 1'b1;
      could_pw_q   <= 1'b1;
      target_q     <= 1'b0;
      seen_q       <= '0;
      failed_q     <= 1'b0;
      ssid_len_q   <= '0;
      pw_len_q     <= '0;
      char_flags_q <= '0;
      body_cnt_q   <= '0;
    end else begin
      esc_q        <= esc_d;
      upper_q      <= upper_d;
      in_value_q   <= in_value_d;
      name_idx_q   <= name_idx_d;
      could_ssid_q <= could_ssid_d;
      could_pw_q   <= could_pw_d;
      target_q     <= target_d;
      seen_q       <= seen_d;
      failed_q     <= failed_d;
      ssid_len_q   <= ssid_len_d;
      pw_len_q     <= pw_len_d;
      char_flags_q <= char_flags_d;
      body_cnt_q   <= body_cnt_d;
    end
  end

  // A final byte always leaves the parser ready for the next body.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && final_i |=> body_cnt_q == '0 && seen_q == '0 && !failed_q && !in_value_q)
    else $error("parser state not cleared after final byte");

endmodule

// File: hw/rtl/fcp_result_fifo.sv
// Small result queue: takes up to two results per cycle, delivers one.
// Depends on fcp_pkg.
`timescale 1ns / 1ps

module fcp_result_fifo import fcp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic [FIFO_PTR_W-1:0] wr_ptr_next;

  assign wr_ptr_next = wr_ptr_q + 1'b1;
  assign count_d     = count_q + FIFO_CNT_W'(push_i.count) - FIFO_CNT_W'(pop_i);
  assign room_o      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign valid_o     = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_i.count);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count == 2'd2 |-> count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    else $error("double push without room");

endmodule

// File: hw/rtl/form_credential_parser_core.sv
// Top level of the form credential parser: input register, parser and
// result queue. Depends on fcp_pkg, fcp_parse and fcp_result_fifo.
//
//   Channel  | Direction | tdata                      | tuser      | tlast
//   s_axis   | in        | body_byte                  | -          | final_byte
//   m_axis   | out       | tag, position, byte, verd. | is_verdict | end_of_run
//
// One body byte is taken per cycle while the result queue has room; each byte
// gives zero or one result, the final byte up to two (value byte, then verdict),
// so the output side sets the rate only at the end of a body. A byte's result
// reaches m_axis through the input register and then the result queue.
// The input register is parsed whenever the queue has two free slots, so a
// stalled output backs up into s_axis_tready_o once the queue holds three results.
// Reset clears all parser state; no clearing pass is needed.
`timescale 1ns / 1ps

module form_credential_parser_core import fcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] body_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [0] field_tag, [6:1] byte_position,
                                        // [14:7] value_byte, [17:15] verdict
  output logic        m_axis_tuser_o,   // is_verdict
  output logic        m_axis_tlast_o    // end_of_run
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;
  logic       fire;
  logic       room;
  logic       s_xfer;
  push_t      push;
  result_t    head;

  assign fire            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_xfer) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q  <= s_axis_tdata_i;
      in_final_q <= s_axis_tlast_i;
    end
  end

  fcp_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .final_i (in_final_q),
    .push_o  (push)
  );

  fcp_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tvalid_o && m_axis_tready_i),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {6'b0, head.verdict, head.value_byte, head.byte_position,
                           head.field_tag};
  assign m_axis_tuser_o = head.is_verdict;
  assign m_axis_tlast_o = head.end_of_run;

  // A verdict always closes the run of results for its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("verdict without end of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> verdict_e'(m_axis_tdata_o[17:15]) == VERDICT_OK)
    else $error("value byte result carries a verdict");

endmodule
